// ===== src/brfifo_pkg.sv =====
// shared types and constants of the byte ring fifo with peek and commit
package brfifo_pkg;

  localparam logic [2:0] CMD_CLEAR  = 3'd0;
  localparam logic [2:0] CMD_WRITE  = 3'd1;
  localparam logic [2:0] CMD_READ   = 3'd2;
  localparam logic [2:0] CMD_PEEK   = 3'd3;
  localparam logic [2:0] CMD_COMMIT = 3'd4;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  localparam logic [7:0] OVF_MAX = 8'd255;

  typedef enum logic {
    ST_IDLE,
    ST_XFER
  } state_t;

  typedef struct packed {
    logic accept;
    logic xfer_step;
  } ctl_t;

  typedef struct packed {
    logic out_free;
    logic xfer_req;
    logic xfer_last;
  } sts_t;

endpackage

// ===== src/brfifo_ram.sv =====
// generic single write port ram with registered read
module brfifo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/brfifo_ctrl.sv =====
// controller state machine: accepts transactions and paces the byte transfers
module brfifo_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  brfifo_pkg::sts_t  sts,
  output brfifo_pkg::ctl_t  ctl
);

  brfifo_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      brfifo_pkg::ST_IDLE: begin
        if (ctl.accept && sts.xfer_req) begin
          state_nxt = brfifo_pkg::ST_XFER;
        end
      end
      brfifo_pkg::ST_XFER: begin
        if (ctl.xfer_step && sts.xfer_last) begin
          state_nxt = brfifo_pkg::ST_IDLE;
        end
      end
      default: state_nxt = brfifo_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = 1'b1;
    ctl.accept    = 1'b0;
    ctl.xfer_step = 1'b0;
    case (state_r)
      brfifo_pkg::ST_IDLE: begin
        in_stall   = !sts.out_free;
        ctl.accept = in_valid && sts.out_free;
      end
      brfifo_pkg::ST_XFER: begin
        ctl.xfer_step = sts.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= brfifo_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/brfifo_dp.sv =====
// datapath: ring indexes, overflow count, storage ram and output register
module brfifo_dp #(
  parameter int DEPTH    = 256,
  parameter int PEEK_MAX = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [2:0]       in_command,
  input  logic [7:0]       in_data_in,
  input  logic [7:0]       in_count,
  input  logic             out_stall,
  input  brfifo_pkg::ctl_t ctl,
  output brfifo_pkg::sts_t sts,
  output logic             out_valid,
  output logic [7:0]       out_data_out,
  output logic             out_data_valid,
  output logic [1:0]       out_status,
  output logic [7:0]       out_done_count,
  output logic [7:0]       out_fill_level,
  output logic [7:0]       out_overflow_count,
  output logic             out_last
);

  localparam int IW = $clog2(DEPTH);
  localparam int LW = $clog2(PEEK_MAX + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
  localparam logic [IW:0]   DEPTH_W  = (IW + 1)'(DEPTH);
  localparam logic [8:0]    PEEK_LIM = 9'(PEEK_MAX);

  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] idx);
    idx_inc = (idx == LAST_IDX) ? '0 : idx + IW'(1);
  endfunction

  logic [IW-1:0] wr_r, wr_nxt;
  logic [IW-1:0] rd_r, rd_nxt;
  logic [IW-1:0] ptr_r, ptr_nxt;
  logic [7:0]    ovf_r, ovf_nxt;
  logic [LW-1:0] left_r, left_nxt;
  logic [7:0]    done_r, done_nxt;

  logic          out_valid_r;
  logic [7:0]    out_data_r;
  logic          out_dv_r;
  logic [1:0]    out_status_r;
  logic [7:0]    out_done_r;
  logic [7:0]    out_fill_r;
  logic [7:0]    out_ovf_r;
  logic          out_last_r;

  logic          ram_we;
  logic          ram_re;
  logic [IW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic [IW:0]   avail_w;
  logic [IW:0]   fill_nxt_w;
  logic [8:0]    clamp_w;
  logic [8:0]    peek_n;
  logic [IW-1:0] commit_n;
  logic [IW:0]   commit_sum;
  logic          full;
  logic          xfer_req;

  logic          load;
  logic [7:0]    ld_data;
  logic          ld_dv;
  logic [1:0]    ld_status;
  logic [7:0]    ld_done;
  logic          ld_last;

  brfifo_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_r),
    .wdata (in_data_in),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    avail_w = {1'b0, wr_r} - {1'b0, rd_r};
    if (wr_r < rd_r) begin
      avail_w = avail_w + DEPTH_W;
    end
    clamp_w    = (9'(in_count) < 9'(avail_w)) ? 9'(in_count) : 9'(avail_w);
    peek_n     = (clamp_w > PEEK_LIM) ? PEEK_LIM : clamp_w;
    commit_n   = IW'(clamp_w);
    commit_sum = {1'b0, rd_r} + {1'b0, commit_n};
    if (commit_sum >= DEPTH_W) begin
      commit_sum = commit_sum - DEPTH_W;
    end
    full = (idx_inc(wr_r) == rd_r);
    xfer_req = ((in_command == brfifo_pkg::CMD_READ) && (avail_w != '0)) ||
               ((in_command == brfifo_pkg::CMD_PEEK) && (peek_n != '0));
  end

  always_comb begin
    wr_nxt    = wr_r;
    rd_nxt    = rd_r;
    ptr_nxt   = ptr_r;
    ovf_nxt   = ovf_r;
    left_nxt  = left_r;
    done_nxt  = done_r;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = rd_r;
    load      = 1'b0;
    ld_data   = '0;
    ld_dv     = 1'b0;
    ld_status = brfifo_pkg::STAT_OK;
    ld_done   = '0;
    ld_last   = 1'b1;
    if (ctl.accept) begin
      load = !xfer_req;
      case (in_command)
        brfifo_pkg::CMD_CLEAR: begin
          wr_nxt  = '0;
          rd_nxt  = '0;
          ovf_nxt = '0;
        end
        brfifo_pkg::CMD_WRITE: begin
          if (full) begin
            ld_status = brfifo_pkg::STAT_FULL;
            if (ovf_r != brfifo_pkg::OVF_MAX) begin
              ovf_nxt = ovf_r + 8'd1;
            end
          end else begin
            ram_we = 1'b1;
            wr_nxt = idx_inc(wr_r);
          end
        end
        brfifo_pkg::CMD_READ: begin
          if (xfer_req) begin
            ram_re   = 1'b1;
            rd_nxt   = idx_inc(rd_r);
            left_nxt = LW'(1);
            done_nxt = '0;
          end else begin
            ld_status = brfifo_pkg::STAT_EMPTY;
          end
        end
        brfifo_pkg::CMD_PEEK: begin
          if (xfer_req) begin
            ram_re   = 1'b1;
            ptr_nxt  = idx_inc(rd_r);
            left_nxt = LW'(peek_n);
            done_nxt = 8'(peek_n);
          end
        end
        brfifo_pkg::CMD_COMMIT: begin
          rd_nxt  = commit_sum[IW-1:0];
          ld_done = 8'(commit_n);
        end
        default: begin
          load = !xfer_req;
        end
      endcase
    end else if (ctl.xfer_step) begin
      load    = 1'b1;
      ld_data = ram_rdata;
      ld_dv   = 1'b1;
      ld_done = done_r;
      ld_last = (left_r == LW'(1));
      if (!ld_last) begin
        ram_re    = 1'b1;
        ram_raddr = ptr_r;
        ptr_nxt   = idx_inc(ptr_r);
        left_nxt  = left_r - LW'(1);
      end
    end
  end

  // fill level after the step
  always_comb begin
    fill_nxt_w = {1'b0, wr_nxt} - {1'b0, rd_nxt};
    if (wr_nxt < rd_nxt) begin
      fill_nxt_w = fill_nxt_w + DEPTH_W;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r        <= '0;
      rd_r        <= '0;
      ovf_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      ovf_r <= ovf_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r  <= ptr_nxt;
    left_r <= left_nxt;
    done_r <= done_nxt;
    if (load) begin
      out_data_r   <= ld_data;
      out_dv_r     <= ld_dv;
      out_status_r <= ld_status;
      out_done_r   <= ld_done;
      out_fill_r   <= 8'(fill_nxt_w);
      out_ovf_r    <= ovf_nxt;
      out_last_r   <= ld_last;
    end
  end

  assign sts.out_free  = !out_valid_r || !out_stall;
  assign sts.xfer_req  = xfer_req;
  assign sts.xfer_last = (left_r == LW'(1));

  assign out_valid          = out_valid_r;
  assign out_data_out       = out_data_r;
  assign out_data_valid     = out_dv_r;
  assign out_status         = out_status_r;
  assign out_done_count     = out_done_r;
  assign out_fill_level     = out_fill_r;
  assign out_overflow_count = out_ovf_r;
  assign out_last           = out_last_r;

endmodule

// ===== src/byte_ring_fifo_peek_commit_core.sv =====
// top level of the byte ring fifo with peek, commit and overflow count
// clear, write, commit, empty read, empty peek: back to back unless stalled, result next cycle
// read: the byte comes from the storage ram through its registered read port
// peek of n bytes: one byte per cycle from the ram port while the output is not stalled
// reset clears the ring indexes, the overflow count and the output valid flag
// storage is not cleared after reset, so there is no initialization pass
module byte_ring_fifo_peek_commit_core #(
  parameter int DEPTH    = 256,
  parameter int PEEK_MAX = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_command,
  input  logic [7:0] in_data_in,
  input  logic [7:0] in_count,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data_out,
  output logic       out_data_valid,
  output logic [1:0] out_status,
  output logic [7:0] out_done_count,
  output logic [7:0] out_fill_level,
  output logic [7:0] out_overflow_count,
  output logic       out_last
);

  brfifo_pkg::ctl_t ctl;
  brfifo_pkg::sts_t sts;

  brfifo_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  brfifo_dp #(
    .DEPTH    (DEPTH),
    .PEEK_MAX (PEEK_MAX)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_command         (in_command),
    .in_data_in         (in_data_in),
    .in_count           (in_count),
    .out_stall          (out_stall),
    .ctl                (ctl),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_data_out       (out_data_out),
    .out_data_valid     (out_data_valid),
    .out_status         (out_status),
    .out_done_count     (out_done_count),
    .out_fill_level     (out_fill_level),
    .out_overflow_count (out_overflow_count),
    .out_last           (out_last)
  );

  // a transaction is only taken when the output register can take its result
  a_accept_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> (!out_valid || !out_stall))
    else $error("input taken while output register blocked");

  // a transaction that needs the ram holds off the next one
  a_xfer_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.accept && sts.xfer_req) |=> in_stall)
    else $error("input not stalled during byte transfer");

  // a byte result never carries an error status
  a_byte_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data_valid) |-> (out_status == brfifo_pkg::STAT_OK))
    else $error("byte result with error status");

  // one slot stays empty
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_fill_level) < DEPTH))
    else $error("fill level beyond ring capacity");

endmodule

// ===== tb/tb_byte_ring_fifo_peek_commit_core.sv =====
// testbench of the byte ring fifo with peek, commit and overflow count
module tb_byte_ring_fifo_peek_commit_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = 256;
  localparam int PEEK_MAX     = 64;
  localparam int LIMIT_CYCLES = 1_500_000;
  localparam int DRAIN_CYCLES = PEEK_MAX + 16;
  localparam int OVF_WRITES   = 8;
  localparam int RANDOM_ITEMS = 165;
  localparam logic [2:0] CMD_TOP = 3'd7;

  typedef struct packed {
    logic [7:0] data;
    logic       data_valid;
    logic [1:0] status;
    logic [7:0] done_count;
    logic [7:0] fill_level;
    logic [7:0] overflow_count;
    logic       last;
  } fifo_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] in_command = brfifo_pkg::CMD_CLEAR;
  logic [7:0] in_data_in = '0;
  logic [7:0] in_count = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_data_out;
  logic       out_data_valid;
  logic [1:0] out_status;
  logic [7:0] out_done_count;
  logic [7:0] out_fill_level;
  logic [7:0] out_overflow_count;
  logic       out_last;

  fifo_result_t pending_results[$];
  logic [7:0]   ring_mem [DEPTH];
  int unsigned  head_idx = 0;
  int unsigned  tail_idx = 0;
  logic [7:0]   drop_count = '0;
  int unsigned  error_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  burst_left = 0;
  int unsigned  stall_mode = 0;
  int unsigned  stall_dwell = 0;
  int unsigned  stall_phase = 0;

  byte_ring_fifo_peek_commit_core #(
    .DEPTH   (DEPTH),
    .PEEK_MAX(PEEK_MAX)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_data_in        (in_data_in),
    .in_count          (in_count),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_data_out      (out_data_out),
    .out_data_valid    (out_data_valid),
    .out_status        (out_status),
    .out_done_count    (out_done_count),
    .out_fill_level    (out_fill_level),
    .out_overflow_count(out_overflow_count),
    .out_last          (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb_byte_ring_fifo_peek_commit_core: FAIL");
      $finish;
    end
  end

  // receiver stall pattern, switching mode every so often
  always @(posedge clk) begin
    stall_phase++;
    if (stall_dwell == 0) begin
      stall_mode = $urandom_range(3);
      stall_dwell = $urandom_range(30, 150);
    end else begin
      stall_dwell--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(2) == 0);
      2: out_stall <= ((stall_phase % 8) < 5);
      default: out_stall <= ((stall_phase % 4) == 0);
    endcase
  end

  function automatic logic [7:0] fifo_fill();
    return 8'((head_idx + DEPTH - tail_idx) % DEPTH);
  endfunction

  function automatic void predict_fifo_results(input logic [2:0] cmd, input logic [7:0] din,
                                               input logic [7:0] cnt);
    int unsigned  avail;
    int unsigned  n;
    int unsigned  pos;
    fifo_result_t res;
    avail = fifo_fill();
    res = '0;
    res.last = 1'b1;
    case (cmd)
      brfifo_pkg::CMD_CLEAR: begin
        head_idx = 0;
        tail_idx = 0;
        drop_count = '0;
      end
      brfifo_pkg::CMD_WRITE: begin
        if ((head_idx + 1) % DEPTH == tail_idx) begin
          if (drop_count != brfifo_pkg::OVF_MAX) drop_count++;
          res.status = brfifo_pkg::STAT_FULL;
        end else begin
          ring_mem[head_idx] = din;
          head_idx = (head_idx + 1) % DEPTH;
        end
      end
      brfifo_pkg::CMD_READ: begin
        if (avail == 0) begin
          res.status = brfifo_pkg::STAT_EMPTY;
        end else begin
          res.data = ring_mem[tail_idx];
          res.data_valid = 1'b1;
          tail_idx = (tail_idx + 1) % DEPTH;
        end
      end
      brfifo_pkg::CMD_PEEK: begin
        n = cnt;
        if (n > avail) n = avail;
        if (n > PEEK_MAX) n = PEEK_MAX;
        if (n != 0) begin
          pos = tail_idx;
          for (int i = 0; i < n; i++) begin
            res.data = ring_mem[pos];
            res.data_valid = 1'b1;
            res.done_count = 8'(n);
            res.fill_level = fifo_fill();
            res.overflow_count = drop_count;
            res.last = (i == n - 1);
            pending_results.push_back(res);
            pos = (pos + 1) % DEPTH;
          end
          return;
        end
      end
      brfifo_pkg::CMD_COMMIT: begin
        n = cnt;
        if (n > avail) n = avail;
        tail_idx = (tail_idx + n) % DEPTH;
        res.done_count = 8'(n);
      end
      default: ;
    endcase
    res.fill_level = fifo_fill();
    res.overflow_count = drop_count;
    pending_results.push_back(res);
  endfunction

  task automatic report_mismatch(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t mismatch on %s: got 0x%02h, expected 0x%02h", $time, field, got, want);
    error_count++;
  endtask

  task automatic check_result();
    fifo_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result with no transaction pending", out_data_out, 8'h00);
      return;
    end
    want = pending_results.pop_front();
    if (out_data_out !== want.data) report_mismatch("data_out", out_data_out, want.data);
    if (out_data_valid !== want.data_valid)
      report_mismatch("data_valid", 8'(out_data_valid), 8'(want.data_valid));
    if (out_status !== want.status) report_mismatch("status", 8'(out_status), 8'(want.status));
    if (out_done_count !== want.done_count)
      report_mismatch("done_count", out_done_count, want.done_count);
    if (out_fill_level !== want.fill_level)
      report_mismatch("fill_level", out_fill_level, want.fill_level);
    if (out_overflow_count !== want.overflow_count)
      report_mismatch("overflow_count", out_overflow_count, want.overflow_count);
    if (out_last !== want.last) report_mismatch("last", 8'(out_last), 8'(want.last));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result();
  end

  // one transaction, in bursts with random gaps between them
  task automatic send_txn(input logic [2:0] cmd, input logic [7:0] din, input logic [7:0] cnt);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(7) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_command <= cmd;
    in_data_in <= din;
    in_count <= cnt;
    do @(posedge clk); while (in_stall);
    predict_fifo_results(cmd, din, cnt);
  endtask

  function automatic logic [7:0] rnd_byte();
    return 8'($urandom);
  endfunction

  task automatic test_directed();
    send_txn(brfifo_pkg::CMD_READ, rnd_byte(), rnd_byte());
    send_txn(brfifo_pkg::CMD_PEEK, rnd_byte(), 8'd255);
    send_txn(brfifo_pkg::CMD_COMMIT, rnd_byte(), 8'd200);
    send_txn(brfifo_pkg::CMD_WRITE, 8'h00, rnd_byte());
    send_txn(brfifo_pkg::CMD_WRITE, 8'hff, rnd_byte());
    send_txn(brfifo_pkg::CMD_WRITE, 8'ha5, rnd_byte());
    send_txn(brfifo_pkg::CMD_WRITE, 8'h5a, rnd_byte());
    send_txn(brfifo_pkg::CMD_PEEK, rnd_byte(), 8'd0);
    send_txn(brfifo_pkg::CMD_PEEK, rnd_byte(), 8'd2);
    send_txn(brfifo_pkg::CMD_PEEK, rnd_byte(), 8'd255);
    send_txn(brfifo_pkg::CMD_READ, rnd_byte(), rnd_byte());
    send_txn(brfifo_pkg::CMD_COMMIT, rnd_byte(), 8'd1);
    send_txn(brfifo_pkg::CMD_COMMIT, rnd_byte(), 8'd0);
    send_txn(brfifo_pkg::CMD_COMMIT, rnd_byte(), 8'd255);
    for (int c = int'(brfifo_pkg::CMD_COMMIT) + 1; c <= int'(CMD_TOP); c++)
      send_txn(3'(c), rnd_byte(), rnd_byte());
    send_txn(brfifo_pkg::CMD_WRITE, 8'h3c, rnd_byte());
    send_txn(brfifo_pkg::CMD_CLEAR, rnd_byte(), rnd_byte());
    send_txn(brfifo_pkg::CMD_READ, rnd_byte(), rnd_byte());
  endtask

  task automatic test_full_and_overflow();
    send_txn(brfifo_pkg::CMD_CLEAR, rnd_byte(), rnd_byte());
    for (int i = 0; i < DEPTH - 1; i++) send_txn(brfifo_pkg::CMD_WRITE, rnd_byte(), rnd_byte());
    send_txn(brfifo_pkg::CMD_PEEK, rnd_byte(), 8'd255);
    send_txn(brfifo_pkg::CMD_PEEK, rnd_byte(), 8'(PEEK_MAX));
    send_txn(brfifo_pkg::CMD_PEEK, rnd_byte(), 8'(PEEK_MAX + 1));
    for (int i = 0; i < OVF_WRITES; i++) send_txn(brfifo_pkg::CMD_WRITE, rnd_byte(), rnd_byte());
    send_txn(brfifo_pkg::CMD_READ, rnd_byte(), rnd_byte());
    send_txn(brfifo_pkg::CMD_WRITE, rnd_byte(), rnd_byte());
    send_txn(brfifo_pkg::CMD_WRITE, rnd_byte(), rnd_byte());
    send_txn(brfifo_pkg::CMD_COMMIT, rnd_byte(), 8'd255);
    send_txn(brfifo_pkg::CMD_READ, rnd_byte(), rnd_byte());
    send_txn(brfifo_pkg::CMD_WRITE, rnd_byte(), rnd_byte());
    send_txn(brfifo_pkg::CMD_CLEAR, rnd_byte(), rnd_byte());
    send_txn(brfifo_pkg::CMD_WRITE, rnd_byte(), rnd_byte());
  endtask

  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned sent;
    int unsigned phase_left;
    int unsigned write_pct;
    int unsigned pick;
    logic [7:0]  amount;
    sent = 0;
    phase_left = 0;
    write_pct = 50;
    while (sent < n_items) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 60);
        case ($urandom_range(2))
          0: write_pct = 80;
          1: write_pct = 25;
          default: write_pct = 50;
        endcase
      end
      pick = $urandom_range(99);
      amount = ($urandom_range(3) == 0) ? rnd_byte() : 8'($urandom_range(0, 12));
      if (pick < 1) begin
        send_txn(brfifo_pkg::CMD_CLEAR, rnd_byte(), rnd_byte());
      end else if (pick < 3) begin
        send_txn(3'($urandom_range(int'(brfifo_pkg::CMD_COMMIT) + 1, int'(CMD_TOP))),
                 rnd_byte(), rnd_byte());
      end else if (pick < write_pct) begin
        send_txn(brfifo_pkg::CMD_WRITE, rnd_byte(), rnd_byte());
      end else begin
        case ($urandom_range(4))
          0, 1: send_txn(brfifo_pkg::CMD_READ, rnd_byte(), rnd_byte());
          2: send_txn(brfifo_pkg::CMD_PEEK, rnd_byte(), amount);
          3: send_txn(brfifo_pkg::CMD_COMMIT, rnd_byte(), amount);
          default: begin
            // look at a packet, then consume it
            send_txn(brfifo_pkg::CMD_PEEK, rnd_byte(), amount);
            send_txn(brfifo_pkg::CMD_COMMIT, rnd_byte(), amount);
            sent++;
          end
        endcase
      end
      sent++;
      phase_left = (phase_left > 0) ? phase_left - 1 : 0;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_and_overflow();
    test_random_traffic(RANDOM_ITEMS);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_byte_ring_fifo_peek_commit_core: PASS");
    end else begin
      $display("tb_byte_ring_fifo_peek_commit_core: FAIL");
    end
    $finish;
  end

endmodule

// ===== byte_ring_fifo_peek_commit_core.f =====
src/brfifo_pkg.sv
src/brfifo_ram.sv
src/brfifo_ctrl.sv
src/brfifo_dp.sv
src/byte_ring_fifo_peek_commit_core.sv
tb/tb_byte_ring_fifo_peek_commit_core.sv
